### rtl/hslkc_pkg.sv
package hslkc_pkg;

  localparam int unsigned WAYS_DEF     = 16;
  localparam int unsigned MAX_SETS_DEF = 64;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned NSETS_W      = 7;
  localparam int unsigned SETO_W       = 6;
  localparam int unsigned WAYO_W       = 4;
  localparam logic [31:0] HASH_INIT    = 32'd5381;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [NSETS_W-1:0] NSETS_RST = 7'd64;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam int unsigned REG_NUM_SETS = 0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_INIT,
    ST_SEARCH,
    ST_VICTIM,
    ST_UPDATE,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

### rtl/hashed_set_lru_key_cache_top.sv
// channel  | ports                                   | handshake
// in       | in_op in_key in_fill_value              | in_valid / in_ready
// out      | out_hit out_value out_evicted out_*     | out_valid / out_ready
// cfg      | psel penable pwrite paddr pwdata prdata | pready tied high
// a lookup runs 8 hash steps, a 32-step restoring modulo, then serial passes over the
// ways through one rank/tag memory port
// a clear goes through ST_OUT to the output register; one item at a time
// after reset a clearing pass over all MAX_SETS*WAYS entries sets the ranks and valid bits,
// in_ready stays low during it
// the result is held in an output register until its transfer, in_ready returns after it
module hashed_set_lru_key_cache_top
  import hslkc_pkg::*;
#(
  parameter int unsigned WAYS     = WAYS_DEF,
  parameter int unsigned MAX_SETS = MAX_SETS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VAL_W-1:0]    in_fill_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic [VAL_W-1:0]    out_value,
  output logic                out_evicted,
  output logic [SETO_W-1:0]   out_set_index,
  output logic [WAYO_W-1:0]   out_way_index,
  output logic [CNT_W-1:0]    out_hit_count,
  output logic [CNT_W-1:0]    out_miss_count,
  output logic [CNT_W-1:0]    out_evict_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned DEPTH = MAX_SETS * WAYS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WW    = $clog2(WAYS);
  localparam int unsigned RW    = $clog2(WAYS);
  localparam logic [RW-1:0] RANK_LRU = RW'(WAYS - 1);

  logic [KEY_W-1:0] tag_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [RW-1:0]    rank_mem [DEPTH];
  logic             vld_mem [DEPTH];

  state_t state_r, state_nxt;
  logic [NSETS_W-1:0] num_sets_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   fill_r;
  logic [31:0]        hash_r, hash_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [SW-1:0]      set_r, set_nxt;
  logic [WW:0]        way_cnt_r, way_cnt_nxt;
  logic [WW-1:0]      way_r, way_nxt;
  logic               found_r, found_nxt;
  logic               hit_r, hit_nxt, ev_r, ev_nxt;
  logic [RW-1:0]      prank_r, prank_nxt;
  logic [VAL_W-1:0]   rval_r, rval_nxt;
  logic [CNT_W-1:0]   hits_r, hits_nxt, miss_r, miss_nxt, evc_r, evc_nxt;
  logic               oval_r, oval_nxt;
  logic               clr_r, clr_nxt;
  logic [AW:0]        clr_cnt_r, clr_cnt_nxt;

  logic [AW-1:0]      rd_addr;
  logic [KEY_W-1:0]   rd_tag;
  logic [VAL_W-1:0]   rd_val;
  logic [RW-1:0]      rd_rank;
  logic               rd_vld;
  logic               rd_ok_r;

  logic               rk_we, tv_we, vl_we;
  logic [AW-1:0]      wr_addr;
  logic [RW-1:0]      rk_wd;
  logic               vl_wd;

  logic [NSETS_W-1:0] sets_eff;
  logic [AW-1:0]      base;
  logic [32:0]        trial;

  always_comb begin
    if (num_sets_r == '0) begin
      sets_eff = NSETS_W'(1);
    end else if (32'(num_sets_r) > MAX_SETS) begin
      sets_eff = NSETS_W'(MAX_SETS);
    end else begin
      sets_eff = num_sets_r;
    end
  end

  assign base = AW'(set_r) * AW'(WAYS);

  assign pready = 1'b1;
  assign prdata = 32'(num_sets_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sets_r <= NSETS_RST;
    end else if (psel && penable && pwrite && (paddr[2] == 1'(REG_NUM_SETS))) begin
      num_sets_r <= pwdata[NSETS_W-1:0];
    end
  end

  // memories
  always_ff @(posedge clk) begin
    rd_tag  <= tag_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
    rd_rank <= rank_mem[rd_addr];
    rd_vld  <= vld_mem[rd_addr];
    if (rk_we) begin
      rank_mem[wr_addr] <= rk_wd;
    end
    if (vl_we) begin
      vld_mem[wr_addr] <= vl_wd;
    end
    if (tv_we) begin
      tag_mem[wr_addr] <= key_r;
      val_mem[wr_addr] <= fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      oval_r    <= 1'b0;
      hits_r    <= '0;
      miss_r    <= '0;
      evc_r     <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      oval_r    <= oval_nxt;
      hits_r    <= hits_nxt;
      miss_r    <= miss_nxt;
      evc_r     <= evc_nxt;
      rd_ok_r   <= (state_r == ST_SEARCH || state_r == ST_VICTIM || state_r == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r  <= in_key;
      fill_r <= in_fill_value;
    end
    hash_r    <= hash_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    set_r     <= set_nxt;
    way_cnt_r <= way_cnt_nxt;
    way_r     <= way_nxt;
    found_r   <= found_nxt;
    hit_r     <= hit_nxt;
    ev_r      <= ev_nxt;
    prank_r   <= prank_nxt;
    rval_r    <= rval_nxt;
  end

  assign trial = {rem_r[31:0], hash_r[31]} - 33'(sets_eff);

  // previous way (the one whose read data is now valid)
  logic [WW-1:0] pway;
  assign pway = WW'(way_cnt_r - 1'b1);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    oval_nxt    = oval_r;
    hits_nxt    = hits_r;
    miss_nxt    = miss_r;
    evc_nxt     = evc_r;
    hash_nxt    = hash_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    set_nxt     = set_r;
    way_cnt_nxt = way_cnt_r;
    way_nxt     = way_r;
    found_nxt   = found_r;
    hit_nxt     = hit_r;
    ev_nxt      = ev_r;
    prank_nxt   = prank_r;
    rval_nxt    = rval_r;
    rd_addr     = base + AW'(way_cnt_r[WW-1:0]);
    rk_we       = 1'b0;
    vl_we       = 1'b0;
    tv_we       = 1'b0;
    wr_addr     = base + AW'(way_r);
    rk_wd       = '0;
    vl_wd       = 1'b1;
    in_ready    = 1'b0;

    if (out_valid && out_ready) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (clr_r) begin
          rk_we   = 1'b1;
          vl_we   = 1'b1;
          vl_wd   = 1'b0;
          wr_addr = clr_cnt_r[AW-1:0];
          rk_wd   = RW'(clr_cnt_r[AW-1:0] % AW'(WAYS));
          clr_cnt_nxt = clr_cnt_r + 1'b1;
          if (clr_cnt_r == (AW+1)'(DEPTH - 1)) begin
            clr_nxt = 1'b0;
          end
        end else if (!oval_r) begin
          in_ready = 1'b1;
          if (in_valid) begin
            if (in_op == OP_CLEAR) begin
              hits_nxt = '0;
              miss_nxt = '0;
              evc_nxt  = '0;
              hit_nxt  = 1'b0;
              ev_nxt   = 1'b0;
              rval_nxt = '0;
              set_nxt  = '0;
              way_nxt  = '0;
              state_nxt = ST_OUT;
            end else begin
              hash_nxt  = HASH_INIT;
              cnt_nxt   = '0;
              state_nxt = ST_HASH;
            end
          end
        end
      end
      ST_HASH: begin
        hash_nxt = (hash_r << 5) + hash_r + 32'(key_r[{cnt_r[2:0], 3'b000} +: 8]);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 6'd7) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!trial[32]) begin
          rem_nxt = trial;
        end else begin
          rem_nxt = {rem_r[31:0], hash_r[31]};
        end
        hash_nxt = hash_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 6'd31) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        set_nxt     = SW'(rem_r);
        way_cnt_nxt = '0;
        found_nxt   = 1'b0;
        way_nxt     = '0;
        state_nxt   = ST_SEARCH;
      end
      ST_SEARCH: begin
        // reads issued in way order, data checked in the following cycle
        if (rd_ok_r && !found_r && rd_vld && rd_tag == key_r) begin
          found_nxt = 1'b1;
          way_nxt   = pway;
          rval_nxt  = rd_val;
          prank_nxt = rd_rank;
        end
        if (way_cnt_r == (WW+1)'(WAYS)) begin
          way_cnt_nxt = '0;
          if (found_nxt) begin
            hit_nxt   = 1'b1;
            ev_nxt    = 1'b0;
            hits_nxt  = (hits_r == CNT_MAX) ? hits_r : hits_r + 1'b1;
            state_nxt = ST_UPDATE;
          end else begin
            hit_nxt   = 1'b0;
            state_nxt = ST_VICTIM;
          end
        end else begin
          way_cnt_nxt = way_cnt_r + 1'b1;
        end
      end
      ST_VICTIM: begin
        if (rd_ok_r && way_cnt_r != '0 && rd_rank == RANK_LRU && !found_r) begin
          found_nxt = 1'b1;
          way_nxt   = pway;
          ev_nxt    = rd_vld;
          prank_nxt = rd_rank;
        end
        if (way_cnt_r == (WW+1)'(WAYS)) begin
          way_cnt_nxt = '0;
          rval_nxt    = fill_r;
          miss_nxt    = (miss_r == CNT_MAX) ? miss_r : miss_r + 1'b1;
          if (ev_nxt) begin
            evc_nxt = (evc_r == CNT_MAX) ? evc_r : evc_r + 1'b1;
          end
          state_nxt = ST_WRITE;
        end else begin
          way_cnt_nxt = way_cnt_r + 1'b1;
        end
      end
      ST_WRITE: begin
        tv_we     = 1'b1;
        vl_we     = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (rd_ok_r && way_cnt_r != '0) begin
          wr_addr = base + AW'(pway);
          if (pway == way_r) begin
            rk_we = 1'b1;
            rk_wd = '0;
          end else if (rd_rank < prank_r) begin
            rk_we = 1'b1;
            rk_wd = rd_rank + 1'b1;
          end
        end
        if (way_cnt_r == (WW+1)'(WAYS)) begin
          state_nxt = ST_OUT;
        end else begin
          way_cnt_nxt = way_cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        oval_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid       = oval_r;
  assign out_hit         = hit_r;
  assign out_value       = rval_r;
  assign out_evicted     = ev_r;
  assign out_set_index   = SETO_W'(set_r);
  assign out_way_index   = WAYO_W'(way_r);
  assign out_hit_count   = hits_r;
  assign out_miss_count  = miss_r;
  assign out_evict_count = evc_r;

endmodule

### bench/hashed_set_lru_key_cache_top_tb.sv
module hashed_set_lru_key_cache_top_tb;
  import hslkc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = 16;
  localparam int NS = 64;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
    logic             evicted;
    logic [5:0]       set_idx;
    logic [3:0]       way_idx;
    logic [CNT_W-1:0] hitc;
    logic [CNT_W-1:0] missc;
    logic [CNT_W-1:0] evc;
  } lookup_res_t;

  class cache_scoreboard;
    logic [KEY_W-1:0] tags[NS*NW];
    logic [VAL_W-1:0] handles[NS*NW];
    bit               present[NS*NW];
    int unsigned      rank[NS*NW];
    logic [CNT_W-1:0] n_hit, n_miss, n_evict;
    logic [6:0]       sets_reg;
    lookup_res_t      pending[$];
    int               errors;

    function new();
      for (int i = 0; i < NS*NW; i++) begin
        present[i] = 0;
        rank[i] = i % NW;
      end
      n_hit = 0;
      n_miss = 0;
      n_evict = 0;
      sets_reg = NSETS_RST;
      errors = 0;
    endfunction

    function logic [31:0] bernstein(logic [KEY_W-1:0] k);
      logic [31:0] h;
      h = HASH_INIT;
      for (int b = 0; b < 8; b++) h = h * 33 + k[8*b +: 8];
      return h;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1;
    endfunction

    function void note_input(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] fill);
      lookup_res_t r;
      int unsigned ns, s, base, w, r0;
      bit found;
      r = '0;
      if (op == OP_CLEAR) begin
        n_hit = 0;
        n_miss = 0;
        n_evict = 0;
        pending.push_back(r);
        return;
      end
      ns = sets_reg;
      if (ns == 0) ns = 1;
      if (ns > NS) ns = NS;
      s = bernstein(k) % ns;
      base = s * NW;
      found = 0;
      w = 0;
      for (int i = 0; i < NW; i++)
        if (!found && present[base+i] && tags[base+i] == k) begin
          found = 1;
          w = i;
        end
      if (found) begin
        r.value = handles[base+w];
        n_hit = bump(n_hit);
      end else begin
        for (int i = NW-1; i >= 0; i--) if (rank[base+i] == NW-1) w = i;
        r.value = fill;
        if (present[base+w]) begin
          r.evicted = 1;
          n_evict = bump(n_evict);
        end
        tags[base+w] = k;
        handles[base+w] = fill;
        present[base+w] = 1;
        n_miss = bump(n_miss);
      end
      r0 = rank[base+w];
      for (int i = 0; i < NW; i++) if (rank[base+i] < r0) rank[base+i]++;
      rank[base+w] = 0;
      r.hit = found;
      r.set_idx = 6'(s);
      r.way_idx = 4'(w);
      r.hitc = n_hit;
      r.missc = n_miss;
      r.evc = n_evict;
      pending.push_back(r);
    endfunction

    function void check_result(lookup_res_t a);
      lookup_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.hit !== a.hit) report("hit", e.hit, a.hit);
      if (e.value !== a.value) report("value", e.value, a.value);
      if (e.evicted !== a.evicted) report("evicted", e.evicted, a.evicted);
      if (e.set_idx !== a.set_idx) report("set_index", e.set_idx, a.set_idx);
      if (e.way_idx !== a.way_idx) report("way_index", e.way_idx, a.way_idx);
      if (e.hitc !== a.hitc) report("hit_count", e.hitc, a.hitc);
      if (e.missc !== a.missc) report("miss_count", e.missc, a.missc);
      if (e.evc !== a.evc) report("evict_count", e.evc, a.evc);
    endfunction

    function void report(string f, logic [63:0] e, logic [63:0] a);
      $display("%0t: %s expected %0h actual %0h", $time, f, e, a);
      errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_op;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_fill_value;
  logic out_valid, out_ready, out_hit, out_evicted;
  logic [VAL_W-1:0] out_value;
  logic [SETO_W-1:0] out_set_index;
  logic [WAYO_W-1:0] out_way_index;
  logic [CNT_W-1:0] out_hit_count, out_miss_count, out_evict_count;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  hashed_set_lru_key_cache_top dut (.*);

  cache_scoreboard sb;
  bit calm;
  int idle_cycles;
  logic [KEY_W-1:0] key_pool[$];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // accepted transfers
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_op, in_key, in_fill_value);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_hit, out_value, out_evicted, out_set_index, out_way_index,
                       out_hit_count, out_miss_count, out_evict_count});
  end

  // receiver stalls
  initial begin
    int n;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("hashed_set_lru_key_cache_top_tb NOT OK");
      $finish;
    end
  end

  task automatic write_num_sets(logic [6:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= 3'(4 * REG_NUM_SETS);
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.sets_reg = v;
  endtask

  task automatic send(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] fill);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_key <= k;
    in_fill_value <= fill;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if (key_pool.size() > 0 && $urandom_range(0, 2) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    k = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) k = k & 64'hff;
    key_pool.push_back(k);
    if (key_pool.size() > 200) void'(key_pool.pop_front());
    return k;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 40) == 0) send(OP_CLEAR, {$urandom, $urandom}, $urandom);
      else send(OP_LOOKUP, pick_key(), $urandom);
    end
  endtask

  initial begin
    logic [6:0] settings[5] = '{7'd1, 7'd0, 7'd127, 7'd5, 7'd64};
    sb = new();
    calm = 0;
    rst_n = 0;
    in_valid = 0;
    in_op = OP_LOOKUP;
    in_key = '0;
    in_fill_value = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: key extremes, id 0, clear, refill of one set beyond its ways
    send(OP_LOOKUP, 64'h0, 32'h0);
    send(OP_LOOKUP, 64'h0, 32'hffffffff);
    send(OP_LOOKUP, 64'hffffffffffffffff, 32'hffffffff);
    send(OP_LOOKUP, 64'hffffffffffffffff, 32'h1);
    send(OP_CLEAR, 64'hffffffffffffffff, 32'hffffffff);
    send(OP_LOOKUP, 64'h0, 32'h5);
    drain();
    write_num_sets(7'd1);
    for (int i = 0; i < 18; i++) send(OP_LOOKUP, 64'(i) << (i * 3), 32'h100 + i);
    send(OP_LOOKUP, 64'h0, 32'h0);
    drain();

    foreach (settings[j]) begin
      write_num_sets(settings[j]);
      random_phase(190);
      drain();
    end
    calm = 1;
    random_phase(60);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("hashed_set_lru_key_cache_top_tb OK");
    else
      $display("hashed_set_lru_key_cache_top_tb NOT OK");
    $finish;
  end
endmodule

### files.f
rtl/hslkc_pkg.sv
rtl/hashed_set_lru_key_cache_top.sv
bench/hashed_set_lru_key_cache_top_tb.sv
